/* rtl/uart_set_time_of_day_clock_unit_macros.svh */
// Assertion macros for the time-of-day clock unit.
// Taken in by the top level; expects a clock named clk and a reset named rst.
`ifndef UART_SET_TIME_OF_DAY_CLOCK_UNIT_MACROS_SVH
`define UART_SET_TIME_OF_DAY_CLOCK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define UCLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define UCLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/uclk_pkg.sv */
// Shared types, codes and tables for the time-of-day clock unit.
// No dependencies; used by the split, sequencer and top-level RTL files.
`default_nettype none

package uclk_pkg;

  // Event kinds
  localparam logic [1:0] OP_SERIAL = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_BUTTON = 2'd2;

  // Burst kinds: which result sequence an event produces
  localparam logic [2:0] K_LED    = 3'd0; // one LED write
  localparam logic [2:0] K_LED2   = 3'd1; // LED write, then LED 128
  localparam logic [2:0] K_SEGLED = 3'd2; // segment write, then LED write
  localparam logic [2:0] K_SET    = 3'd3; // "SET" CR LF
  localparam logic [2:0] K_TICK   = 3'd4; // HH:MM:SS CR LF with segment writes

  // Characters
  localparam logic [7:0] CH_AT    = 8'd64;
  localparam logic [7:0] CH_S     = 8'd83;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_SLASH = 8'd47;

  localparam logic [7:0]  LED_ENTRY = 8'd128;
  localparam logic [16:0] DAY_LAST  = 17'd86399;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [2:0] buttons;
  } ev_t;

  typedef struct packed {
    logic       uart_valid;
    logic [7:0] uart_byte;
    logic       seg_valid;
    logic [2:0] seg_position;
    logic [6:0] seg_code;
    logic       led_valid;
    logic [7:0] led_value;
    logic       last;
  } res_t;

  // What an event produces, as carried down the pipeline
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] led_value;
    logic [2:0] seg_position;
    logic [6:0] seg_code;
  } desc_t;

  // Active-low seven-segment pattern of a decimal digit
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'd64;
      4'd1:    c = 7'd121;
      4'd2:    c = 7'd36;
      4'd3:    c = 7'd48;
      4'd4:    c = 7'd25;
      4'd5:    c = 7'd18;
      4'd6:    c = 7'd2;
      4'd7:    c = 7'd120;
      4'd8:    c = 7'd0;
      4'd9:    c = 7'd16;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/uclk_split.sv */
// Three-stage split of a seconds count into six decimal digits (HH MM SS).
// Uses uclk_pkg; descriptors of other events ride through unchanged.
`default_nettype none

module uclk_split (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 job_valid,
  output logic                      job_ready,
  input  wire uclk_pkg::desc_t      job_desc,
  input  wire logic [16:0]          job_secs,
  output logic                      burst_valid,
  input  wire logic                 burst_ready,
  output uclk_pkg::desc_t           burst_desc,
  output logic [5:0][3:0]           burst_digits
);

  // Tens and units of a value below 64
  function automatic logic [7:0] split10(input logic [5:0] x);
    logic [3:0] tn;
    logic [5:0] t6;
    logic [5:0] un;
    if (x >= 6'd60)      tn = 4'd6;
    else if (x >= 6'd50) tn = 4'd5;
    else if (x >= 6'd40) tn = 4'd4;
    else if (x >= 6'd30) tn = 4'd3;
    else if (x >= 6'd20) tn = 4'd2;
    else if (x >= 6'd10) tn = 4'd1;
    else                 tn = 4'd0;
    t6 = {2'b00, tn};
    un = x - ((t6 << 3) + (t6 << 1));
    return {tn, un[3:0]};
  endfunction

  logic            s2_valid, s3_valid, s4_valid;
  logic            s2_ready, s3_ready, s4_ready;
  uclk_pkg::desc_t s2_desc, s3_desc, s4_desc;
  logic [16:0]     s2_secs;
  logic [4:0]      s2_hours, s3_hours;
  logic [11:0]     s3_rem;
  logic [5:0]      s3_mins;
  logic [5:0][3:0] s4_digits;

  // hours = secs / 3600 by reciprocal, exact below one day
  logic [35:0] prod_h;
  assign prod_h = {19'd0, job_secs} * 36'd298262;

  // remainder within the hour, minutes = rem / 60 by reciprocal
  logic [16:0] h17;
  logic [16:0] rem17;
  logic [26:0] prod_m;
  assign h17    = {12'd0, s2_hours};
  assign rem17  = s2_secs - ((h17 << 11) + (h17 << 10) + (h17 << 9) + (h17 << 4));
  assign prod_m = {15'd0, rem17[11:0]} * 27'd17477;

  // seconds and the six digits
  logic [11:0] m12;
  logic [11:0] sec12;
  logic [7:0]  hsplit, msplit, ssplit;
  assign m12    = {6'd0, s3_mins};
  assign sec12  = s3_rem - ((m12 << 6) - (m12 << 2));
  assign hsplit = split10({1'b0, s3_hours});
  assign msplit = split10(s3_mins);
  assign ssplit = split10(sec12[5:0]);

  // Ready chain
  assign s4_ready  = !s4_valid || burst_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign job_ready = s2_ready;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s2_ready) s2_valid <= job_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_desc  <= job_desc;
      s2_secs  <= job_secs;
      s2_hours <= prod_h[34:30];
    end
    if (s3_ready) begin
      s3_desc  <= s2_desc;
      s3_hours <= s2_hours;
      s3_rem   <= rem17[11:0];
      s3_mins  <= prod_m[25:20];
    end
    if (s4_ready) begin
      s4_desc      <= s3_desc;
      s4_digits[0] <= hsplit[7:4];
      s4_digits[1] <= hsplit[3:0];
      s4_digits[2] <= msplit[7:4];
      s4_digits[3] <= msplit[3:0];
      s4_digits[4] <= ssplit[7:4];
      s4_digits[5] <= ssplit[3:0];
    end
  end

  assign burst_valid  = s4_valid;
  assign burst_desc   = s4_desc;
  assign burst_digits = s4_digits;

endmodule

`default_nettype wire

/* rtl/uclk_emit.sv */
// Burst register and result sequencer: expands one event's burst into results.
// Uses uclk_pkg; drives the registered result channel of the top level.
`default_nettype none

module uclk_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 burst_valid,
  output logic                      burst_ready,
  input  wire uclk_pkg::desc_t      burst_desc,
  input  wire logic [5:0][3:0]      burst_digits,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output uclk_pkg::res_t            res_data
);

  logic            b_valid;
  uclk_pkg::desc_t b_desc;
  logic [5:0][3:0] b_digits;
  logic [3:0]      idx;
  logic [3:0]      n_res;
  logic            is_last;
  logic            load;
  uclk_pkg::res_t  res_next;
  logic [2:0]      dpos;
  logic [3:0]      dval;

  // Results per burst kind
  always_comb begin
    case (b_desc.kind)
      uclk_pkg::K_LED:    n_res = 4'd1;
      uclk_pkg::K_LED2:   n_res = 4'd2;
      uclk_pkg::K_SEGLED: n_res = 4'd2;
      uclk_pkg::K_SET:    n_res = 4'd5;
      uclk_pkg::K_TICK:   n_res = 4'd10;
      default:            n_res = 4'd1;
    endcase
  end

  assign is_last     = (idx == n_res - 4'd1);
  assign load        = b_valid && (!res_valid || !res_stall);
  assign burst_ready = !b_valid || (load && is_last);

  // Display position of a tick result slot
  always_comb begin
    case (idx)
      4'd0:    dpos = 3'd0;
      4'd1:    dpos = 3'd1;
      4'd3:    dpos = 3'd2;
      4'd4:    dpos = 3'd3;
      4'd6:    dpos = 3'd4;
      4'd7:    dpos = 3'd5;
      default: dpos = 3'd0;
    endcase
  end
  assign dval = b_digits[dpos];

  // Result at the current slot
  always_comb begin
    res_next      = '0;
    res_next.last = is_last;
    case (b_desc.kind)
      uclk_pkg::K_LED: begin
        res_next.led_valid = 1'b1;
        res_next.led_value = b_desc.led_value;
      end
      uclk_pkg::K_LED2: begin
        res_next.led_valid = 1'b1;
        res_next.led_value = (idx == 4'd0) ? b_desc.led_value : uclk_pkg::LED_ENTRY;
      end
      uclk_pkg::K_SEGLED: begin
        if (idx == 4'd0) begin
          res_next.seg_valid    = 1'b1;
          res_next.seg_position = b_desc.seg_position;
          res_next.seg_code     = b_desc.seg_code;
        end else begin
          res_next.led_valid = 1'b1;
          res_next.led_value = b_desc.led_value;
        end
      end
      uclk_pkg::K_SET: begin
        res_next.uart_valid = 1'b1;
        case (idx)
          4'd0:    res_next.uart_byte = uclk_pkg::CH_S;
          4'd1:    res_next.uart_byte = uclk_pkg::CH_E;
          4'd2:    res_next.uart_byte = uclk_pkg::CH_T;
          4'd3:    res_next.uart_byte = uclk_pkg::CH_CR;
          default: res_next.uart_byte = uclk_pkg::CH_LF;
        endcase
      end
      uclk_pkg::K_TICK: begin
        res_next.uart_valid = 1'b1;
        case (idx)
          4'd2, 4'd5: res_next.uart_byte = uclk_pkg::CH_COLON;
          4'd8:       res_next.uart_byte = uclk_pkg::CH_CR;
          4'd9:       res_next.uart_byte = uclk_pkg::CH_LF;
          default: begin
            res_next.uart_byte    = uclk_pkg::CH_ZERO + {4'd0, dval};
            res_next.seg_valid    = 1'b1;
            res_next.seg_position = dpos;
            res_next.seg_code     = uclk_pkg::seg_of(dval);
          end
        endcase
      end
      default: begin
        res_next.last = 1'b1;
      end
    endcase
  end

  // Burst and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      idx       <= 4'd0;
      res_valid <= 1'b0;
    end else begin
      if (burst_ready) begin
        b_valid <= burst_valid;
        idx     <= 4'd0;
      end else if (load) begin
        idx <= idx + 4'd1;
      end
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // Burst and output payload
  always_ff @(posedge clk) begin
    if (burst_ready) begin
      b_desc   <= burst_desc;
      b_digits <= burst_digits;
    end
    if (load) res_data <= res_next;
  end

endmodule

`default_nettype wire

/* rtl/uart_set_time_of_day_clock_unit.sv */
// Time-of-day clock set over a serial link. Events (serial poll, one-second
// tick, button poll) are taken one per cycle, unless ev_stall is high, into an
// input register; the mode, entry position, entered digits and seconds count
// update in the cycle that moves an event on, so consecutive events need no
// gaps. A tick's count is then split into HH MM SS over three pipeline stages,
// and a sequencer hands out the event's results one per cycle, while res_stall
// is low, through a registered output. The sustained rate is set by the result
// sequencer: one result for a single LED write, two for '@', a digit or button
// 7, five for "SET" CR LF and ten for a tick. Events that cause no result leave
// the input stage without passing anything down the pipeline.
// Depends on uclk_pkg, uclk_split, uclk_emit and the assertion macro header.
`default_nettype none

`include "uart_set_time_of_day_clock_unit_macros.svh"

module uart_set_time_of_day_clock_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ev_valid,
  output logic                 ev_stall,
  input  wire uclk_pkg::ev_t   ev_data,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output uclk_pkg::res_t       res_data
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SETTING = 2'd1;
  localparam logic [1:0] MODE_RUN     = 2'd2;

  // Clock state
  logic [1:0]      mode, mode_next;
  logic [2:0]      entry_pos, entry_pos_next;
  logic [5:0][7:0] digits, digits_next;
  logic [23:0]     seconds_count, seconds_count_next;

  // Input register
  logic          r0_valid;
  uclk_pkg::ev_t r0_data;
  logic          fire1;
  logic          s1_go;

  // Stage 1 output register
  logic            r1_valid;
  logic            r1_ready;
  uclk_pkg::desc_t r1_desc;
  logic [16:0]     r1_secs;

  logic            has_res;
  uclk_pkg::desc_t desc_next;
  logic [16:0]     secs_out;

  logic            burst_valid;
  logic            burst_ready;
  uclk_pkg::desc_t burst_desc;
  logic [5:0][3:0] burst_digits;

  logic [7:0]  d_val;
  logic [24:0] t_inc;
  logic [24:0] t_new;
  logic [2:0]  pos_inc;
  logic [11:0] hh, mm, ss;
  logic [23:0] h24, m24, s24, set_secs;

  logic        tick_fire;
  logic [23:0] day_last;

  // Two decimal digits to a value
  function automatic logic [11:0] pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [11:0] h;
    h = {4'd0, hi};
    return (h << 3) + (h << 1) + {4'd0, lo};
  endfunction

  // Handshake of the input and stage-1 registers
  assign s1_go    = !r1_valid || r1_ready;
  assign fire1    = r0_valid && s1_go;
  assign ev_stall = r0_valid && !s1_go;

  // Seconds from the entered digits
  assign hh       = pair(digits[0], digits[1]);
  assign mm       = pair(digits[2], digits[3]);
  assign ss       = pair(digits[4], digits[5]);
  assign h24      = {12'd0, hh};
  assign m24      = {12'd0, mm};
  assign s24      = {12'd0, ss};
  assign set_secs = (h24 << 11) + (h24 << 10) + (h24 << 9) + (h24 << 4)
                  + (m24 << 6) - (m24 << 2) + s24;

  assign d_val   = r0_data.rx_byte - uclk_pkg::CH_ZERO;
  assign pos_inc = entry_pos + 3'd1;
  assign t_inc   = {1'b0, seconds_count} + 25'd1;
  assign t_new   = (t_inc > {8'd0, uclk_pkg::DAY_LAST}) ? 25'd0 : t_inc;

  // Event decode and state update
  always_comb begin
    mode_next          = mode;
    entry_pos_next     = entry_pos;
    digits_next        = digits;
    seconds_count_next = seconds_count;
    has_res            = 1'b0;
    desc_next          = '0;
    secs_out           = '0;
    if (mode != MODE_RUN) begin
      if (r0_data.operation == uclk_pkg::OP_SERIAL) begin
        has_res = 1'b1;
        if (r0_data.rx_byte == uclk_pkg::CH_AT) begin
          entry_pos_next      = 3'd0;
          mode_next           = MODE_SETTING;
          desc_next.kind      = uclk_pkg::K_LED2;
          desc_next.led_value = uclk_pkg::LED_ENTRY;
        end else if (mode != MODE_SETTING) begin
          desc_next.kind = uclk_pkg::K_SET;
        end else if (r0_data.rx_byte > uclk_pkg::CH_SLASH) begin
          if (entry_pos < 3'd6) begin
            digits_next[entry_pos] = d_val;
            entry_pos_next         = pos_inc;
            desc_next.led_value    = uclk_pkg::LED_ENTRY | {5'd0, pos_inc};
            if (d_val <= 8'd9) begin
              desc_next.kind         = uclk_pkg::K_SEGLED;
              desc_next.seg_position = entry_pos;
              desc_next.seg_code     = uclk_pkg::seg_of(d_val[3:0]);
            end else begin
              desc_next.kind = uclk_pkg::K_LED;
            end
          end else if (entry_pos == 3'd6) begin
            entry_pos_next      = 3'd7;
            desc_next.kind      = uclk_pkg::K_LED;
            desc_next.led_value = uclk_pkg::LED_ENTRY | 8'd7;
          end else begin
            seconds_count_next  = set_secs;
            entry_pos_next      = 3'd0;
            mode_next           = MODE_RUN;
            desc_next.kind      = uclk_pkg::K_LED;
            desc_next.led_value = 8'd0;
          end
        end else begin
          desc_next.kind      = uclk_pkg::K_LED;
          desc_next.led_value = uclk_pkg::LED_ENTRY | {5'd0, entry_pos};
        end
      end
    end else begin
      if (r0_data.operation == uclk_pkg::OP_TICK) begin
        has_res            = 1'b1;
        seconds_count_next = t_new[23:0];
        secs_out           = t_new[16:0];
        desc_next.kind     = uclk_pkg::K_TICK;
      end else if (r0_data.operation == uclk_pkg::OP_BUTTON) begin
        has_res             = 1'b1;
        desc_next.led_value = {5'd0, r0_data.buttons};
        if (r0_data.buttons == 3'd7) begin
          desc_next.kind = uclk_pkg::K_LED2;
          entry_pos_next = 3'd0;
          mode_next      = MODE_IDLE;
        end else begin
          desc_next.kind = uclk_pkg::K_LED;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid      <= 1'b0;
      r1_valid      <= 1'b0;
      mode          <= MODE_IDLE;
      entry_pos     <= 3'd0;
      digits        <= '0;
      seconds_count <= 24'd0;
    end else begin
      if (ev_valid && !ev_stall) r0_valid <= 1'b1;
      else if (fire1) r0_valid <= 1'b0;
      if (fire1) begin
        r1_valid      <= has_res;
        mode          <= mode_next;
        entry_pos     <= entry_pos_next;
        digits        <= digits_next;
        seconds_count <= seconds_count_next;
      end else if (r1_ready) begin
        r1_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ev_valid && !ev_stall) r0_data <= ev_data;
    if (fire1) begin
      r1_desc <= desc_next;
      r1_secs <= secs_out;
    end
  end

  uclk_split u_split (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (r1_valid),
    .job_ready    (r1_ready),
    .job_desc     (r1_desc),
    .job_secs     (r1_secs),
    .burst_valid  (burst_valid),
    .burst_ready  (burst_ready),
    .burst_desc   (burst_desc),
    .burst_digits (burst_digits)
  );

  uclk_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .burst_valid  (burst_valid),
    .burst_ready  (burst_ready),
    .burst_desc   (burst_desc),
    .burst_digits (burst_digits),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_data     (res_data)
  );

  // Tick moving on, and the last second of the day at count width
  assign tick_fire = fire1 && mode == MODE_RUN && r0_data.operation == uclk_pkg::OP_TICK;
  assign day_last  = {7'd0, uclk_pkg::DAY_LAST};

  // Checks
  `UCLK_ASSERT_NOW(a_run_pos_clear, mode == MODE_RUN, entry_pos == 3'd0, "pos set while running")
  `UCLK_ASSERT_NOW(a_idle_pos_clear, mode == MODE_IDLE, entry_pos == 3'd0, "pos set while idle")
  `UCLK_ASSERT_NEXT(a_tick_in_day, tick_fire, seconds_count <= day_last, "count beyond one day")

endmodule

`default_nettype wire
